>>> src/lsbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbf_pkg: shared types and constants of the length sorted batch former
// Sizes of the pending store, field widths, codes and the sequencer states.
// ----------------------------------------------------------------------------
package lsbf_pkg;

  localparam int PendingDepth = 32;
  localparam int LengthBits   = 12;
  localparam int MaxResults   = 32;
  localparam int TagBits      = 16;
  localparam int SumBits      = 18;
  localparam int LimitBits    = 6;

  localparam int IdxW = (PendingDepth > 1) ? $clog2(PendingDepth) : 1;
  localparam int CntW = $clog2(PendingDepth + 1);
  localparam int OrdW = (MaxResults > 1) ? $clog2(MaxResults) : 1;
  localparam int TakW = $clog2(MaxResults + 1);

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_FORM = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_FULL   = 2'd1,
    ST_MEMBER = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_LIMIT  = 2'd0,
    REG_BUDGET = 2'd1,
    REG_MODE   = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_EMIT_RD,
    S_EMIT,
    S_COMPACT
  } state_e;

  typedef struct packed {
    logic [TagBits-1:0]    tag;
    logic [LengthBits-1:0] len;
  } entry_t;

endpackage

>>> src/lsbf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbf_in_if / lsbf_out_if: valid-ready channels of the batch former
// Command beats in, result beats out.
// ----------------------------------------------------------------------------
interface lsbf_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] request_id;
  logic [11:0] token_length;

  modport source  (output valid, opcode, request_id, token_length, input ready);
  modport sink    (input valid, opcode, request_id, token_length, output ready);
  modport monitor (input valid, opcode, request_id, token_length, ready);
endinterface

interface lsbf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] member_id;
  logic [11:0] member_length;
  logic [11:0] padded_length;
  logic        last;

  modport source  (output valid, status, member_id, member_length, padded_length, last,
                   input ready);
  modport sink    (input valid, status, member_id, member_length, padded_length, last,
                   output ready);
  modport monitor (input valid, status, member_id, member_length, padded_length, last,
                   ready);
endinterface

>>> src/lsbf_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbf_store: pending request memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lsbf_store (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [lsbf_pkg::IdxW-1:0] waddr_i,
  input  lsbf_pkg::entry_t        wdata_i,
  input  logic [lsbf_pkg::IdxW-1:0] raddr_i,
  output lsbf_pkg::entry_t        rdata_o
);
  import lsbf_pkg::*;

  entry_t mem_q [PendingDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> src/length_sorted_batch_former.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_sorted_batch_former: token budget dynamic batching
// Holds pending requests and forms batches shortest first under limits, or in store order.
// ----------------------------------------------------------------------------
// An add command, or a form command with nothing pending, is taken in the
// idle state and answers with one beat. A form command with N pending
// requests runs a single compare unit over the pending store through its
// one read port; each pass reads all N entries. In sorted mode each member
// costs one pass plus a decision step, and a batch ended early by the limit
// or the budget costs one more pass and decision; in unsorted mode the
// batch takes one pass. Then each member is read from the store and sent
// as one beat, waiting out any output stall, and a final pass compacts the
// store. The block takes no command until the store is compacted and the
// output register is free.
module length_sorted_batch_former (
  input  logic         clk_i,
  input  logic         rst_ni,
  lsbf_in_if.sink      in_i,
  lsbf_out_if.source   out_o,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [17:0]  cfg_data_i
);
  import lsbf_pkg::*;

  state_e state_q, state_d;

  logic [LimitBits-1:0]  limit_q;
  logic [SumBits-1:0]    budget_q;
  logic                  mode_q;

  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [CntW-1:0]       a_q, a_d;
  logic                  pv_q, pv_d;
  logic [IdxW-1:0]       p_q, p_d;
  logic                  bv_q, bv_d;
  logic [IdxW-1:0]       best_q, best_d;
  logic [LengthBits-1:0] blen_q, blen_d;
  logic [TakW-1:0]       taken_q, taken_d;
  logic [SumBits-1:0]    sum_q, sum_d;
  logic [LengthBits-1:0] pad_q, pad_d;
  logic [OrdW-1:0]       j_q, j_d;
  logic [CntW-1:0]       w_q, w_d;
  logic [PendingDepth-1:0] mark_q, mark_d;
  logic [IdxW-1:0]       order_q [MaxResults];
  logic                  ord_we;
  logic [OrdW-1:0]       ord_waddr;
  logic [IdxW-1:0]       ord_wdata;

  logic                  ov_q, ov_d;
  logic [1:0]            ost_q, ost_d;
  logic [TagBits-1:0]    oid_q, oid_d;
  logic [LengthBits-1:0] olen_q, olen_d;
  logic [LengthBits-1:0] opad_q, opad_d;
  logic                  olast_q, olast_d;

  logic                  m_we;
  logic [IdxW-1:0]       m_waddr, m_raddr;
  entry_t                m_wdata, m_rdata;

  logic                  out_free, issue, pass_done, accept;
  logic [TakW:0]         taken_inc;
  logic [SumBits:0]      sum_try;

  lsbf_store u_store (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_waddr),
    .wdata_i (m_wdata),
    .raddr_i (m_raddr),
    .rdata_o (m_rdata)
  );

  assign out_free  = !ov_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && out_free;
  assign accept    = in_i.valid && in_i.ready;
  assign issue     = (a_q < cnt_q);
  assign pass_done = !issue && !pv_q;
  assign taken_inc = {1'b0, taken_q} + (TakW+1)'(1);
  assign sum_try   = {1'b0, sum_q} + (SumBits+1)'(blen_q);

  assign out_o.valid         = ov_q;
  assign out_o.status        = ost_q;
  assign out_o.member_id     = oid_q;
  assign out_o.member_length = olen_q;
  assign out_o.padded_length = opad_q;
  assign out_o.last          = olast_q;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;  a_d = a_q;  pv_d = 1'b0;  p_d = a_q[IdxW-1:0];
    bv_d = bv_q;  best_d = best_q;  blen_d = blen_q;
    taken_d = taken_q;  sum_d = sum_q;  pad_d = pad_q;
    j_d = j_q;  w_d = w_q;  mark_d = mark_q;
    ord_we = 1'b0;  ord_waddr = taken_q[OrdW-1:0];  ord_wdata = best_q;
    ov_d = ov_q && !out_o.ready;
    ost_d = ost_q;  oid_d = oid_q;  olen_d = olen_q;  opad_d = opad_q;  olast_d = olast_q;
    m_we = 1'b0;
    m_waddr = cnt_q[IdxW-1:0];
    m_wdata = '{tag: in_i.request_id, len: in_i.token_length};
    m_raddr = a_q[IdxW-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ov_d = 1'b1;  oid_d = '0;  olen_d = '0;  opad_d = '0;  olast_d = 1'b1;
          if (in_i.opcode == OP_ADD) begin
            if (cnt_q == CntW'(PendingDepth)) begin
              ost_d = ST_FULL;
            end else begin
              ost_d = ST_ACCEPT;
              m_we  = 1'b1;
              cnt_d = cnt_q + CntW'(1);
            end
          end else if (cnt_q == '0) begin
            ost_d = ST_EMPTY;
          end else begin
            ov_d = ov_q && !out_o.ready;
            mark_d = '0;  taken_d = '0;  sum_d = '0;  pad_d = '0;
            a_d = '0;  bv_d = 1'b0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          pv_d = 1'b1;
          a_d  = a_q + CntW'(1);
        end
        if (pv_q) begin
          if (mode_q) begin
            if (!mark_q[p_q] && (!bv_q || m_rdata.len < blen_q)) begin
              bv_d = 1'b1;  best_d = p_q;  blen_d = m_rdata.len;
            end
          end else if ({1'b0, p_q} < (IdxW+1)'(MaxResults)) begin
            mark_d[p_q] = 1'b1;
            ord_we = 1'b1;  ord_waddr = OrdW'(p_q);  ord_wdata = p_q;
            if (m_rdata.len > pad_q) pad_d = m_rdata.len;
          end
        end
        if (pass_done) begin
          if (mode_q) begin
            state_d = S_DECIDE;
          end else begin
            taken_d = (cnt_q > CntW'(MaxResults)) ? TakW'(MaxResults) : TakW'(cnt_q);
            j_d = '0;
            state_d = S_EMIT_RD;
          end
        end
      end
      S_DECIDE: begin
        if (taken_q != '0 &&
            ({1'b0, taken_q} >= (TakW+1)'(limit_q) || sum_try > {1'b0, budget_q})) begin
          j_d = '0;
          state_d = S_EMIT_RD;
        end else begin
          mark_d[best_q] = 1'b1;
          ord_we = 1'b1;
          sum_d = sum_try[SumBits-1:0];
          if (blen_q > pad_q) pad_d = blen_q;
          taken_d = taken_inc[TakW-1:0];
          a_d = '0;  bv_d = 1'b0;
          if (taken_inc == (TakW+1)'(cnt_q) || taken_inc == (TakW+1)'(MaxResults)) begin
            j_d = '0;
            state_d = S_EMIT_RD;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_EMIT_RD: begin
        m_raddr = order_q[j_q];
        state_d = S_EMIT;
      end
      S_EMIT: begin
        m_raddr = order_q[j_q];
        if (out_free) begin
          ov_d = 1'b1;  ost_d = ST_MEMBER;
          oid_d = m_rdata.tag;  olen_d = m_rdata.len;  opad_d = pad_q;
          olast_d = ((TakW+1)'(j_q) + (TakW+1)'(1) == (TakW+1)'(taken_q));
          if (olast_d) begin
            a_d = '0;  w_d = '0;
            state_d = S_COMPACT;
          end else begin
            j_d = j_q + OrdW'(1);
            state_d = S_EMIT_RD;
          end
        end
      end
      S_COMPACT: begin
        if (issue) begin
          pv_d = 1'b1;
          a_d  = a_q + CntW'(1);
        end
        if (pv_q && !mark_q[p_q]) begin
          m_we = 1'b1;  m_waddr = w_q[IdxW-1:0];  m_wdata = m_rdata;
          w_d = w_q + CntW'(1);
        end
        if (pass_done) begin
          cnt_d = w_q;
          mark_d = '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;  a_q <= '0;  pv_q <= 1'b0;  bv_q <= 1'b0;
      taken_q <= '0;  j_q <= '0;  w_q <= '0;  mark_q <= '0;  ov_q <= 1'b0;
      limit_q <= LimitBits'(8);  budget_q <= SumBits'(2048);  mode_q <= 1'b1;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;  a_q <= a_d;  pv_q <= pv_d;  bv_q <= bv_d;
      taken_q <= taken_d;  j_q <= j_d;  w_q <= w_d;  mark_q <= mark_d;  ov_q <= ov_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LIMIT:  limit_q  <= cfg_data_i[LimitBits-1:0];
          REG_BUDGET: budget_q <= cfg_data_i[SumBits-1:0];
          REG_MODE:   mode_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;  best_q <= best_d;  blen_q <= blen_d;
    sum_q <= sum_d;  pad_q <= pad_d;
    ost_q <= ost_d;  oid_q <= oid_d;  olen_q <= olen_d;  opad_q <= opad_d;
    olast_q <= olast_d;
    if (ord_we) begin
      order_q[ord_waddr] <= ord_wdata;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(PendingDepth))
    else $error("pending count above depth");
  a_member_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ost_q == ST_MEMBER && !$stable(oid_q)) |-> $past(state_q) == S_EMIT)
    else $error("member beat outside emit");
  a_compact_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && $past(state_q) == S_COMPACT) |-> cnt_q < $past(cnt_q))
    else $error("batch removed nothing");
  a_taken_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (taken_q != '0 && (CntW+1)'(taken_q) <= (CntW+1)'(cnt_q)))
    else $error("taken count out of range");
`endif
endmodule
